[hdl/qvr_pkg.sv]
// ----------------------------------------------------------------------------
// qvr_pkg
// Shared widths, types and register codes for the quaternion vector rotator.
// ----------------------------------------------------------------------------
package qvr_pkg;

    localparam int COMP_W  = 16;
    localparam int FRAC_W  = 14;
    localparam int P1_W    = 2 * COMP_W;
    localparam int T_W     = P1_W + 1;
    localparam int P2_W    = T_W + COMP_W;
    localparam int S_W     = P2_W + 2;
    localparam int SHIFT_W = 2 * FRAC_W;
    localparam int RND_W   = S_W + 1 - SHIFT_W;

    localparam int CFG_ADDR_W = 2;

    localparam logic [CFG_ADDR_W-1:0] REG_ROT_W = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_X = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_Y = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_ROT_Z = 2'd3;

    localparam logic signed [COMP_W-1:0] ROT_W_RST = 16'sd16384;
    localparam logic signed [COMP_W-1:0] ROT_V_RST = 16'sd0;

    typedef struct packed {
        logic signed [COMP_W-1:0] w;
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
    } t_quat;

    typedef struct packed {
        logic signed [COMP_W-1:0] z;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] x;
    } t_vec;

    typedef struct packed {
        logic signed [T_W-1:0] w;
        logic signed [T_W-1:0] x;
        logic signed [T_W-1:0] y;
        logic signed [T_W-1:0] z;
    } t_tquat;

    typedef struct packed {
        logic signed [S_W-1:0] x;
        logic signed [S_W-1:0] y;
        logic signed [S_W-1:0] z;
    } t_rvec;

endpackage

[hdl/qvr_left_product.sv]
// ----------------------------------------------------------------------------
// qvr_left_product
// Two-stage pipeline forming t = q * (0, a, b, c): partial products, then sums.
// ----------------------------------------------------------------------------
module qvr_left_product
    import qvr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_vec   i_vec,
    input  t_quat  i_quat,
    output logic   o_valid,
    input  logic   i_ready,
    output t_tquat o_t
);

    logic r_va, r_vb;
    logic en_a, en_b;

    logic signed [P1_W-1:0] r_wa, r_wb, r_wc;
    logic signed [P1_W-1:0] r_xa, r_xb, r_xc;
    logic signed [P1_W-1:0] r_ya, r_yb, r_yc;
    logic signed [P1_W-1:0] r_za, r_zb, r_zc;
    t_tquat r_t, n_t;

    assign en_b    = !r_vb || i_ready;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vb;
    assign o_t     = r_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_wa <= i_quat.w * i_vec.x;
            r_wb <= i_quat.w * i_vec.y;
            r_wc <= i_quat.w * i_vec.z;
            r_xa <= i_quat.x * i_vec.x;
            r_xb <= i_quat.x * i_vec.y;
            r_xc <= i_quat.x * i_vec.z;
            r_ya <= i_quat.y * i_vec.x;
            r_yb <= i_quat.y * i_vec.y;
            r_yc <= i_quat.y * i_vec.z;
            r_za <= i_quat.z * i_vec.x;
            r_zb <= i_quat.z * i_vec.y;
            r_zc <= i_quat.z * i_vec.z;
        end
        if (en_b) begin
            r_t <= n_t;
        end
    end

    always_comb begin
        n_t.w = -T_W'(r_xa) - T_W'(r_yb) - T_W'(r_zc);
        n_t.x =  T_W'(r_wa) + T_W'(r_yc) - T_W'(r_zb);
        n_t.y =  T_W'(r_wb) - T_W'(r_xc) + T_W'(r_za);
        n_t.z =  T_W'(r_wc) + T_W'(r_xb) - T_W'(r_ya);
    end

endmodule

[hdl/qvr_right_product.sv]
// ----------------------------------------------------------------------------
// qvr_right_product
// Two-stage pipeline forming the vector part of t * conj(q).
// ----------------------------------------------------------------------------
module qvr_right_product
    import qvr_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_valid,
    output logic   o_ready,
    input  t_tquat i_t,
    input  t_quat  i_quat,
    output logic   o_valid,
    input  logic   i_ready,
    output t_rvec  o_r
);

    logic r_va, r_vb;
    logic en_a, en_b;

    logic signed [P2_W-1:0] r_twx, r_twy, r_twz;
    logic signed [P2_W-1:0] r_txw, r_txy, r_txz;
    logic signed [P2_W-1:0] r_tyw, r_tyx, r_tyz;
    logic signed [P2_W-1:0] r_tzw, r_tzx, r_tzy;
    t_rvec r_r, n_r;

    assign en_b    = !r_vb || i_ready;
    assign en_a    = !r_va || en_b;
    assign o_ready = en_a;
    assign o_valid = r_vb;
    assign o_r     = r_r;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            if (en_a) begin
                r_va <= i_valid;
            end
            if (en_b) begin
                r_vb <= r_va;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en_a) begin
            r_twx <= i_t.w * i_quat.x;
            r_twy <= i_t.w * i_quat.y;
            r_twz <= i_t.w * i_quat.z;
            r_txw <= i_t.x * i_quat.w;
            r_txy <= i_t.x * i_quat.y;
            r_txz <= i_t.x * i_quat.z;
            r_tyw <= i_t.y * i_quat.w;
            r_tyx <= i_t.y * i_quat.x;
            r_tyz <= i_t.y * i_quat.z;
            r_tzw <= i_t.z * i_quat.w;
            r_tzx <= i_t.z * i_quat.x;
            r_tzy <= i_t.z * i_quat.y;
        end
        if (en_b) begin
            r_r <= n_r;
        end
    end

    always_comb begin
        n_r.x = -S_W'(r_twx) + S_W'(r_txw) - S_W'(r_tyz) + S_W'(r_tzy);
        n_r.y = -S_W'(r_twy) + S_W'(r_txz) + S_W'(r_tyw) - S_W'(r_tzx);
        n_r.z = -S_W'(r_twz) - S_W'(r_txy) + S_W'(r_tyx) + S_W'(r_tzw);
    end

endmodule

[hdl/qvr_round_sat.sv]
// ----------------------------------------------------------------------------
// qvr_round_sat
// Output stage: round to nearest, saturate to 16 bits, flag clipping.
// ----------------------------------------------------------------------------
module qvr_round_sat
    import qvr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_valid,
    output logic  o_ready,
    input  t_rvec i_r,
    output logic  o_valid,
    input  logic  i_ready,
    output t_vec  o_vec,
    output logic  o_clip
);

    localparam logic signed [S_W:0]   HALF    = (S_W+1)'(1) <<< (SHIFT_W - 1);
    localparam logic signed [RND_W-1:0] MAX_V = RND_W'(32767);
    localparam logic signed [RND_W-1:0] MIN_V = -RND_W'(32768);

    logic  r_v;
    logic  en;
    t_vec  r_vec, n_vec;
    logic  r_clip, n_clip;
    logic  clip_x, clip_y, clip_z;

    function automatic logic signed [COMP_W-1:0] sat(
        input  logic signed [S_W-1:0] v,
        output logic                  clip
    );
        logic signed [S_W:0]    biased;
        logic signed [RND_W-1:0] rnd;
        begin
            biased = (S_W+1)'(v) + HALF;
            rnd    = biased[S_W:SHIFT_W];
            clip   = 1'b0;
            if (rnd > MAX_V) begin
                clip = 1'b1;
                sat  = MAX_V[COMP_W-1:0];
            end else if (rnd < MIN_V) begin
                clip = 1'b1;
                sat  = MIN_V[COMP_W-1:0];
            end else begin
                sat  = rnd[COMP_W-1:0];
            end
        end
    endfunction

    assign en      = !r_v || i_ready;
    assign o_ready = en;
    assign o_valid = r_v;
    assign o_vec   = r_vec;
    assign o_clip  = r_clip;

    always_comb begin
        n_vec.x = sat(i_r.x, clip_x);
        n_vec.y = sat(i_r.y, clip_y);
        n_vec.z = sat(i_r.z, clip_z);
        n_clip  = clip_x || clip_y || clip_z;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (en) begin
            r_v <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_vec  <= n_vec;
            r_clip <= n_clip;
        end
    end

endmodule

[hdl/quaternion_vector_rotate.sv]
// ----------------------------------------------------------------------------
// quaternion_vector_rotate
// Rotates a streamed 3D vector by the configured Q2.14 quaternion, q*p*conj(q).
//
//   channel  direction  content
//   s_*      in         vector request: x, y, z
//   m_*      out        rotated x, y, z and clip flag
//   i_cfg_*  in         register write: rot_w, rot_x, rot_y, rot_z
//
// One vector per cycle while m_tready is high; two multiplier stages, two adder
// stages and one rounding/output stage. Each stage holds its own valid bit and
// advances when its successor has room, so bubbles are squeezed out under
// stall and nothing is dropped. Reset clears all valid bits and loads the
// identity quaternion. Write registers only while the pipeline is empty.
// ----------------------------------------------------------------------------
module quaternion_vector_rotate
    import qvr_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [47:0]           s_tdata,   // in_x[15:0], in_y[31:16], in_z[47:32]
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [47:0]           m_tdata,   // out_x[15:0], out_y[31:16], out_z[47:32]
    output logic                  m_tuser,   // clipped[0]
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [COMP_W-1:0]     i_cfg_data
);

    t_quat  r_quat;
    t_vec   in_vec, out_vec;
    t_tquat t_val;
    t_rvec  r_val;
    logic   l_valid, l_ready;
    logic   r_valid, r_ready;
    logic   out_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w <= ROT_W_RST;
            r_quat.x <= ROT_V_RST;
            r_quat.y <= ROT_V_RST;
            r_quat.z <= ROT_V_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                REG_ROT_W: r_quat.w <= i_cfg_data;
                REG_ROT_X: r_quat.x <= i_cfg_data;
                REG_ROT_Y: r_quat.y <= i_cfg_data;
                REG_ROT_Z: r_quat.z <= i_cfg_data;
                default:   r_quat   <= r_quat;
            endcase
        end
    end

    assign in_vec = s_tdata;

    qvr_left_product u_left (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_tvalid),
        .o_ready (s_tready),
        .i_vec   (in_vec),
        .i_quat  (r_quat),
        .o_valid (l_valid),
        .i_ready (l_ready),
        .o_t     (t_val)
    );

    qvr_right_product u_right (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (l_valid),
        .o_ready (l_ready),
        .i_t     (t_val),
        .i_quat  (r_quat),
        .o_valid (r_valid),
        .i_ready (r_ready),
        .o_r     (r_val)
    );

    qvr_round_sat u_round (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_valid),
        .o_ready (r_ready),
        .i_r     (r_val),
        .o_valid (m_tvalid),
        .i_ready (m_tready),
        .o_vec   (out_vec),
        .o_clip  (out_clip)
    );

    assign m_tdata = out_vec;
    assign m_tuser = out_clip;

endmodule

[verif/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams vectors through the quaternion rotator under a range of rotation
// settings and random idling on both sides. Every result is checked against
// an exact integer rotation, rounded half up and saturated to 16 bits.
// ----------------------------------------------------------------------------
module tb;
    import qvr_pkg::*;

    localparam int WATCHDOG_LIMIT = 1000;
    localparam int LONG_HOLD      = 150;
    localparam int SETTLE         = 8;
    localparam int RAND_PHASES    = 8;
    localparam int PHASE_ITEMS    = 100;

    typedef struct {
        logic signed [COMP_W-1:0] x;
        logic signed [COMP_W-1:0] y;
        logic signed [COMP_W-1:0] z;
        logic                     clip;
    } t_rot_result;

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  s_tvalid   = 1'b0;
    logic                  s_tready;
    logic [47:0]           s_tdata    = '0;  // in_x[15:0], in_y[31:16], in_z[47:32]
    logic                  m_tvalid;
    logic                  m_tready   = 1'b0;
    logic [47:0]           m_tdata;          // out_x[15:0], out_y[31:16], out_z[47:32]
    logic                  m_tuser;          // clipped[0]
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr = '0;
    logic [COMP_W-1:0]     i_cfg_data = '0;

    t_vec        vector_q[$];
    t_rot_result rotated_q[$];
    t_quat       rotation = '{w: ROT_W_RST, x: ROT_V_RST, y: ROT_V_RST, z: ROT_V_RST};

    int  queued_total   = 0;
    int  received_total = 0;
    int  clipped_total  = 0;
    int  settings_total = 1;
    int  errors         = 0;
    int  quiet_cycles   = 0;
    int  src_idle_pct   = 0;
    int  snk_idle_pct   = 0;
    int  src_gap        = 0;
    int  snk_gap        = 0;
    int  holds_asked    = 0;
    int  holds_done     = 0;
    int  hold_left      = 0;
    bit  req_fired      = 1'b0;

    quaternion_vector_rotate i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // round half up from scale 2^28, saturate; bit 16 flags saturation
    function automatic logic [COMP_W:0] round_sat(input longint v);
        longint r;
        r = (v + (longint'(1) <<< 27)) >>> 28;
        if (r > 32767)
            return {1'b1, 16'h7fff};
        if (r < -32768)
            return {1'b1, 16'h8000};
        return {1'b0, r[COMP_W-1:0]};
    endfunction

    function automatic t_rot_result rotate_vector(input t_quat q, input t_vec v);
        longint          w, x, y, z, a, b, c;
        longint          tw, tx, ty, tz;
        logic [COMP_W:0] ox, oy, oz;
        t_rot_result     res;
        w = q.w;
        x = q.x;
        y = q.y;
        z = q.z;
        a = v.x;
        b = v.y;
        c = v.z;
        tw = -x * a - y * b - z * c;
        tx =  w * a + y * c - z * b;
        ty =  w * b - x * c + z * a;
        tz =  w * c + x * b - y * a;
        ox = round_sat(-tw * x + tx * w - ty * z + tz * y);
        oy = round_sat(-tw * y + tx * z + ty * w - tz * x);
        oz = round_sat(-tw * z - tx * y + ty * x + tz * w);
        res.x    = ox[COMP_W-1:0];
        res.y    = oy[COMP_W-1:0];
        res.z    = oz[COMP_W-1:0];
        res.clip = ox[COMP_W] | oy[COMP_W] | oz[COMP_W];
        return res;
    endfunction

    // request driver
    always @(negedge i_clk) begin
        if (!s_tvalid || req_fired) begin
            if (src_gap > 0) begin
                src_gap  = src_gap - 1;
                s_tvalid <= 1'b0;
            end else if (i_rst_n && vector_q.size() > 0) begin
                if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
                    src_gap  = $urandom_range(11, 1) - 1;
                    s_tvalid <= 1'b0;
                end else begin
                    s_tdata  <= vector_q.pop_front();
                    s_tvalid <= 1'b1;
                end
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // result receiver
    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_done < holds_asked) begin
            holds_done = holds_done + 1;
            hold_left  = LONG_HOLD - 1;
            m_tready   <= 1'b0;
        end else if (snk_gap > 0) begin
            snk_gap  = snk_gap - 1;
            m_tready <= 1'b0;
        end else if (snk_idle_pct != 0 && $urandom_range(99) < snk_idle_pct) begin
            snk_gap  = $urandom_range(11, 1) - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
        end
    end

    // monitor, checker and watchdog
    always @(posedge i_clk) begin
        t_rot_result exp_res;
        req_fired = s_tvalid && s_tready;
        if (i_rst_n && m_tvalid && m_tready) begin
            received_total = received_total + 1;
            if (rotated_q.size() == 0) begin
                $error("result with nothing expected: %h clip %b", m_tdata, m_tuser);
                errors = errors + 1;
            end else begin
                exp_res = rotated_q.pop_front();
                if (exp_res.clip)
                    clipped_total = clipped_total + 1;
                if ($signed(m_tdata[15:0]) !== exp_res.x) begin
                    $error("out_x: expected %0d, got %0d", exp_res.x, $signed(m_tdata[15:0]));
                    errors = errors + 1;
                end
                if ($signed(m_tdata[31:16]) !== exp_res.y) begin
                    $error("out_y: expected %0d, got %0d", exp_res.y, $signed(m_tdata[31:16]));
                    errors = errors + 1;
                end
                if ($signed(m_tdata[47:32]) !== exp_res.z) begin
                    $error("out_z: expected %0d, got %0d", exp_res.z, $signed(m_tdata[47:32]));
                    errors = errors + 1;
                end
                if (m_tuser !== exp_res.clip) begin
                    $error("clipped: expected %0b, got %0b", exp_res.clip, m_tuser);
                    errors = errors + 1;
                end
            end
        end
        if (i_rst_n && req_fired)
            rotated_q.push_back(rotate_vector(rotation, t_vec'(s_tdata)));
        if (req_fired || (m_tvalid && m_tready) || i_cfg_we)
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: %0d results outstanding", rotated_q.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic push_vec(input logic signed [COMP_W-1:0] x,
                            input logic signed [COMP_W-1:0] y,
                            input logic signed [COMP_W-1:0] z);
        vector_q.push_back('{x: x, y: y, z: z});
        queued_total = queued_total + 1;
    endtask

    // hold until every queued request has come back, then let the pipe settle
    task automatic drain();
        while (received_total != queued_total)
            @(negedge i_clk);
        repeat (SETTLE) @(negedge i_clk);
    endtask

    task automatic load_rotation(input logic signed [COMP_W-1:0] w,
                                 input logic signed [COMP_W-1:0] x,
                                 input logic signed [COMP_W-1:0] y,
                                 input logic signed [COMP_W-1:0] z);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= REG_ROT_W;
        i_cfg_data <= w;
        @(negedge i_clk);
        i_cfg_addr <= REG_ROT_X;
        i_cfg_data <= x;
        @(negedge i_clk);
        i_cfg_addr <= REG_ROT_Y;
        i_cfg_data <= y;
        @(negedge i_clk);
        i_cfg_addr <= REG_ROT_Z;
        i_cfg_data <= z;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        rotation       = '{w: w, x: x, y: y, z: z};
        settings_total = settings_total + 1;
    endtask

    function automatic logic signed [COMP_W-1:0] rand_comp(input int kind);
        case (kind)
            0: return COMP_W'($urandom_range(128) - 64);
            1: case ($urandom_range(4))
                   0: return 16'sh7fff;
                   1: return 16'sh8000;
                   2: return 16'sd0;
                   3: return -16'sd1;
                   default: return 16'sd1;
               endcase
            default: return COMP_W'($urandom);
        endcase
    endfunction

    initial begin
        int kind;
        int axis;
        int sgn;
        logic signed [COMP_W-1:0] q[4];
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        src_idle_pct = 20;
        snk_idle_pct = 20;

        // identity rotation out of reset: extremes pass through untouched
        @(posedge i_clk);
        push_vec(16'sd0, 16'sd0, 16'sd0);
        push_vec(16'sh7fff, 16'sh7fff, 16'sh7fff);
        push_vec(16'sh8000, 16'sh8000, 16'sh8000);
        push_vec(16'sh7fff, 16'sh8000, 16'sd0);
        push_vec(-16'sd1, 16'sd1, -16'sd1);
        push_vec(16'sd1, -16'sd1, 16'sd1);
        push_vec(16'sd12345, -16'sd23456, 16'sd31000);
        drain();

        // half scale: quarter results hit exact rounding ties of both signs
        load_rotation(16'sd8192, 16'sd0, 16'sd0, 16'sd0);
        @(posedge i_clk);
        push_vec(16'sd2, -16'sd2, 16'sd6);
        push_vec(-16'sd6, 16'sd3, -16'sd3);
        push_vec(16'sh7fff, 16'sh8000, 16'sd1);
        drain();

        // unnormalized extremes: full-scale inputs saturate
        load_rotation(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        @(posedge i_clk);
        push_vec(16'sh7fff, 16'sh8000, 16'sd1);
        push_vec(16'sd0, 16'sd0, 16'sd0);
        push_vec(16'sd1, 16'sd0, 16'sd0);
        drain();

        load_rotation(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        @(posedge i_clk);
        push_vec(16'sh8000, 16'sh7fff, -16'sd1);
        push_vec(16'sd100, 16'sd200, 16'sd300);
        drain();

        // half turn about x: negating the most negative value clips
        load_rotation(16'sd0, 16'sd16384, 16'sd0, 16'sd0);
        @(posedge i_clk);
        push_vec(16'sd1000, -16'sd2000, 16'sd3000);
        push_vec(16'sh8000, 16'sh8000, 16'sh8000);
        drain();

        // quarter turn about z
        load_rotation(16'sd11585, 16'sd0, 16'sd0, 16'sd11585);
        @(posedge i_clk);
        push_vec(16'sh7fff, 16'sd0, 16'sd0);
        push_vec(16'sd0, 16'sh8000, 16'sd0);
        drain();

        for (int p = 0; p < RAND_PHASES; p++) begin
            case ($urandom_range(2))
                0: for (int i = 0; i < 4; i++) q[i] = COMP_W'($urandom);
                1: for (int i = 0; i < 4; i++) q[i] = COMP_W'($urandom_range(23170) - 11585);
                default: begin
                    axis = $urandom_range(3);
                    sgn  = $urandom_range(1);
                    for (int i = 0; i < 4; i++)
                        q[i] = (i == axis) ? (sgn ? -16'sd16384 : 16'sd16384) : 16'sd0;
                end
            endcase
            load_rotation(q[0], q[1], q[2], q[3]);
            if (p == RAND_PHASES - 1 || p == 2) begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end else begin
                src_idle_pct = $urandom_range(40, 5);
                snk_idle_pct = $urandom_range(40, 5);
            end
            // stall the receiver while requests keep coming
            if (p == 3) begin
                src_idle_pct = 0;
                holds_asked  = holds_asked + 1;
            end
            @(posedge i_clk);
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                kind = $urandom_range(19);
                kind = (kind < 3) ? 0 : (kind < 6) ? 1 : 2;
                push_vec(rand_comp(kind), rand_comp(kind), rand_comp(kind));
            end
            drain();
        end

        $display("%0d vectors rotated under %0d quaternion settings, %0d results saturated",
                 received_total, settings_total, clipped_total);
        if (errors == 0 && rotated_q.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[sim.f]
hdl/qvr_pkg.sv
hdl/qvr_left_product.sv
hdl/qvr_right_product.sv
hdl/qvr_round_sat.sv
hdl/quaternion_vector_rotate.sv
verif/tb.sv
